// ----- rtl/mhfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mhfs_pkg
// Types, character codes and per-byte parse functions of the header splitter.
// ----------------------------------------------------------------------------
package mhfs_pkg;

  localparam logic [7:0] ChrColon = 8'h3A;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [2:0] TagLen   = 3'd5;

  localparam int unsigned OffW     = 16;
  localparam int unsigned NumW     = 15;
  localparam int unsigned TdataW   = 80;
  localparam int unsigned TuserW   = 3;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [2:0] {
    KIND_FIELD   = 3'd0,
    KIND_END     = 3'd1,
    KIND_NOCOLON = 3'd2,
    KIND_UNTERM  = 3'd3,
    KIND_OVF     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PH_AWAIT    = 4'b0001,
    PH_IN_FIELD = 4'b0010,
    PH_PENDING  = 4'b0100,
    PH_IDLE     = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [OffW-1:0]   field_origin;
    logic              colon_seen;
    logic [OffW-1:0]   name_end;
    logic [OffW-1:0]   value_origin;
    logic              skipping;
    logic [2:0]        prefix_cnt;
    logic [OffW-1:0]   nl_pos;
    logic [OffW-1:0]   fields;      // one bit above the field number range
  } parse_st_t;

  typedef struct packed {
    kind_e             kind;
    logic [NumW-1:0]   num;
    logic [OffW-1:0]   name_begin;
    logic [OffW-1:0]   name_stop;
    logic [OffW-1:0]   value_begin;
    logic [OffW-1:0]   value_stop;
    logic              last;
  } rec_t;

  typedef struct packed {
    parse_st_t st;
    rec_t      rec;
  } close_t;

  typedef struct packed {
    parse_st_t st;
    logic      emit;
    rec_t      rec;
  } start_t;

  localparam parse_st_t ParseStReset = '{
    phase: PH_AWAIT, field_origin: '0, colon_seen: 1'b0, name_end: '0,
    value_origin: '0, skipping: 1'b0, prefix_cnt: '0, nl_pos: '0, fields: '0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChrSpace) || (b == ChrTab);
  endfunction

  // Bytes of the unix envelope tag "From ".
  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6D;
      3'd4:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic rec_t mk_rec(input kind_e kind, input logic [OffW-1:0] num,
                                  input logic [OffW-1:0] nb, input logic [OffW-1:0] ns,
                                  input logic [OffW-1:0] vb, input logic [OffW-1:0] vs);
    rec_t r;
    r.kind        = kind;
    r.num         = num[NumW-1:0];
    r.name_begin  = nb;
    r.name_stop   = ns;
    r.value_begin = vb;
    r.value_stop  = vs;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic parse_st_t feed(input parse_st_t st_in, input logic [7:0] b,
                                     input logic [OffW-1:0] p);
    parse_st_t       st;
    logic [OffW-1:0] k;
    logic [OffW-1:0] p1;
    st = st_in;
    k  = p - st.field_origin;
    p1 = p + OffW'(1);
    if (st.prefix_cnt < TagLen && OffW'(st.prefix_cnt) == k &&
        b == tag_byte(st.prefix_cnt)) begin
      st.prefix_cnt = st.prefix_cnt + 3'd1;
    end
    if (!st.colon_seen) begin
      if (b == ChrColon) begin
        st.colon_seen   = 1'b1;
        st.value_origin = p1;
        st.skipping     = 1'b1;
      end else if (!is_blank(b)) begin
        st.name_end = p1;
      end
    end else if (st.skipping) begin
      if (is_blank(b)) begin
        st.value_origin = p1;
      end else begin
        st.skipping = 1'b0;
      end
    end
    return st;
  endfunction

  function automatic close_t close_field(input parse_st_t st_in);
    close_t r;
    logic   unix_from;
    r.st      = st_in;
    unix_from = (st_in.prefix_cnt == TagLen);
    if (!unix_from && !st_in.colon_seen) begin
      r.st.phase = PH_IDLE;
      r.rec      = mk_rec(KIND_NOCOLON, st_in.fields, '0, '0, '0, '0);
    end else if (st_in.fields[OffW-1]) begin
      r.st.phase = PH_IDLE;
      r.rec      = mk_rec(KIND_OVF, st_in.fields, '0, '0, '0, '0);
    end else begin
      if (unix_from) begin
        r.rec = mk_rec(KIND_FIELD, st_in.fields, st_in.field_origin,
                       st_in.field_origin + OffW'(TagLen),
                       st_in.field_origin + OffW'(TagLen), st_in.nl_pos);
      end else begin
        r.rec = mk_rec(KIND_FIELD, st_in.fields, st_in.field_origin,
                       st_in.name_end, st_in.value_origin, st_in.nl_pos);
      end
      r.st.fields = st_in.fields + OffW'(1);
      r.st.phase  = PH_AWAIT;
    end
    return r;
  endfunction

  function automatic start_t start_or_stop(input parse_st_t st_in, input logic [7:0] b,
                                           input logic [OffW-1:0] p);
    start_t r;
    r.st   = st_in;
    r.emit = 1'b0;
    r.rec  = mk_rec(KIND_END, st_in.fields, '0, '0, '0, '0);
    if (is_blank(b) || b == ChrLf) begin
      r.st.phase = PH_IDLE;
      r.emit     = 1'b1;
    end else begin
      r.st.field_origin = p;
      r.st.colon_seen   = 1'b0;
      r.st.name_end     = p;
      r.st.value_origin = '0;
      r.st.skipping     = 1'b0;
      r.st.prefix_cnt   = '0;
      r.st.phase        = PH_IN_FIELD;
      r.st              = feed(r.st, b, p);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mail_header_field_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// mail_header_field_splitter_unit
// Splits a mail header, one byte per item, into field name/value offsets.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser        | tlast
//  --------+-----+--------------------------------+--------------+-----------
//  s_axis  | in  | data_byte                      | -            | final_byte
//  m_axis  | out | field_number, name/value spans | record_kind  | run_last
//
//  Takes one byte per cycle unless stalled; the byte is registered and parsed
//  once the queue has room, and its records land in a four-entry record queue.
//  A byte that yields two records leaves as two output records; the queue absorbs
//  that, and the input stalls only while fewer than two queue slots are free.
//  Reset clears the parse state and the queue; no clearing pass is needed.
//  Stalls on m_axis hold the head record stable and back up into s_axis.
//
module mail_header_field_splitter_unit #(
  parameter int unsigned MAX_HEADER_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [14:0] field_number, [30:15] name_begin, [46:31] name_stop,
  // [62:47] value_begin, [78:63] value_stop, [79] zero
  output logic [mhfs_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic [mhfs_pkg::TuserW-1:0] m_axis_tuser_o,  // [2:0] record_kind
  output logic        m_axis_tlast_o    // run_last
);
  import mhfs_pkg::*;

  // Input register: holds one byte until the queue has room for its records.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       step;
  logic       room_two;
  logic       s_acc;

  rec_t       rec0, rec1, head;
  logic [1:0] rec_cnt;
  logic [1:0] push_cnt;
  logic       q_not_empty;

  assign step            = in_vld_q && room_two;
  assign s_axis_tready_o = !in_vld_q || step;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  // Payload: load on accept only.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_fin_q  <= s_axis_tlast_i;
    end
  end

  mhfs_parser #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .final_byte_i(in_fin_q),
    .rec0_o      (rec0),
    .rec1_o      (rec1),
    .rec_cnt_o   (rec_cnt)
  );

  // Push records only on a real parse step.
  assign push_cnt = step ? rec_cnt : 2'd0;

  mhfs_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (rec0),
    .push1_i    (rec1),
    .pop_i      (m_axis_tready_i),
    .room_two_o (room_two),
    .not_empty_o(q_not_empty),
    .head_o     (head)
  );

  assign m_axis_tvalid_o = q_not_empty;
  assign m_axis_tdata_o  = {1'b0, head.value_stop, head.value_begin, head.name_stop,
                            head.name_begin, head.num};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

endmodule

// ----- rtl/mhfs_parser.sv -----
// ----------------------------------------------------------------------------
// mhfs_parser
// Parse state and per-byte step; yields up to two records per byte.
// ----------------------------------------------------------------------------
module mhfs_parser #(
  parameter int unsigned MAX_HEADER_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output mhfs_pkg::rec_t       rec0_o,
  output mhfs_pkg::rec_t       rec1_o,
  output logic [1:0]           rec_cnt_o
);
  import mhfs_pkg::*;

  localparam int unsigned PosLimit = (MAX_HEADER_BYTES < 65536) ? MAX_HEADER_BYTES : 65536;
  localparam int unsigned PosW     = $clog2(PosLimit + 1);

  logic [PosW-1:0] pos_q, pos_d;
  parse_st_t       st_q, st_d;
  rec_t            recs [2];
  logic [1:0]      cnt;

  always_comb begin
    logic [OffW-1:0] p16;
    logic            at_limit;
    close_t          cf;
    start_t          ss;
    st_d     = st_q;
    pos_d    = pos_q;
    cnt      = 2'd0;
    recs[0]  = mk_rec(KIND_END, '0, '0, '0, '0, '0);
    recs[1]  = mk_rec(KIND_END, '0, '0, '0, '0, '0);
    p16      = OffW'(pos_q);
    at_limit = (pos_q >= PosW'(PosLimit));
    cf       = close_field(st_q);
    ss       = start_or_stop(st_q, data_byte_i, p16);

    if (st_d.phase != PH_IDLE) begin
      if (at_limit) begin
        st_d.phase    = PH_IDLE;
        recs[cnt[0]]  = mk_rec(KIND_OVF, st_d.fields, '0, '0, '0, '0);
        cnt           = cnt + 2'd1;
      end else begin
        unique case (st_d.phase)
          PH_AWAIT: begin
            ss   = start_or_stop(st_d, data_byte_i, p16);
            st_d = ss.st;
            if (ss.emit) begin
              recs[cnt[0]] = ss.rec;
              cnt          = cnt + 2'd1;
            end
          end
          PH_IN_FIELD: begin
            st_d = feed(st_d, data_byte_i, p16);
            if (data_byte_i == ChrLf) begin
              st_d.nl_pos = p16;
              st_d.phase  = PH_PENDING;
            end
          end
          PH_PENDING: begin
            if (is_blank(data_byte_i)) begin
              // Folded line: the field continues.
              st_d       = feed(st_d, data_byte_i, p16);
              st_d.phase = PH_IN_FIELD;
            end else begin
              cf           = close_field(st_d);
              st_d         = cf.st;
              recs[cnt[0]] = cf.rec;
              cnt          = cnt + 2'd1;
              if (st_d.phase != PH_IDLE) begin
                ss   = start_or_stop(st_d, data_byte_i, p16);
                st_d = ss.st;
                if (ss.emit) begin
                  recs[cnt[0]] = ss.rec;
                  cnt          = cnt + 2'd1;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (final_byte_i) begin
      unique case (st_d.phase)
        PH_IN_FIELD: begin
          recs[cnt[0]] = mk_rec(KIND_UNTERM, st_d.fields, '0, '0, '0, '0);
          cnt          = cnt + 2'd1;
        end
        PH_PENDING: begin
          cf           = close_field(st_d);
          recs[cnt[0]] = cf.rec;
          cnt          = cnt + 2'd1;
          if (cf.st.phase != PH_IDLE) begin
            recs[cnt[0]] = mk_rec(KIND_END, cf.st.fields, '0, '0, '0, '0);
            cnt          = cnt + 2'd1;
          end
        end
        PH_AWAIT: begin
          recs[cnt[0]] = mk_rec(KIND_END, st_d.fields, '0, '0, '0, '0);
          cnt          = cnt + 2'd1;
        end
        default: ;
      endcase
      st_d  = ParseStReset;
      pos_d = '0;
    end else if (!at_limit) begin
      pos_d = pos_q + PosW'(1);
    end

    recs[0].last = (cnt == 2'd1);
    recs[1].last = 1'b1;
  end

  assign rec0_o    = recs[0];
  assign rec1_o    = recs[1];
  assign rec_cnt_o = cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      st_q  <= ParseStReset;
    end else if (step_i) begin
      pos_q <= pos_d;
      st_q  <= st_d;
    end
  end

endmodule

// ----- rtl/mhfs_result_fifo.sv -----
// ----------------------------------------------------------------------------
// mhfs_result_fifo
// Small record queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module mhfs_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_cnt_i,
  input  mhfs_pkg::rec_t push0_i,
  input  mhfs_pkg::rec_t push1_i,
  input  logic           pop_i,
  output logic           room_two_o,
  output logic           not_empty_o,
  output mhfs_pkg::rec_t head_o
);
  import mhfs_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  rec_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign room_two_o  = (cnt_q <= (PtrW+1)'(FifoDepth - 2));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + PtrW'(push_cnt_i);
    rd_d  = rd_q + PtrW'(do_pop);
    cnt_d = cnt_q + (PtrW+1)'(push_cnt_i) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/mhfs_checker.sv -----
// ----------------------------------------------------------------------------
// mhfs_checker
// Port-level checks of the header splitter, bound to the top level.
// ----------------------------------------------------------------------------
module mhfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import mhfs_pkg::*;

  // A stalled record holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("record changed under stall");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= KIND_OVF))
    else $error("record kind out of range");

  // End and error records carry no offsets.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_FIELD |-> m_axis_tdata_o[79:15] == '0)
    else $error("offsets on a terminating record");

  // End and error records are always the final record of their byte.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_FIELD |-> m_axis_tlast_o)
    else $error("terminating record not marked last");

endmodule

bind mail_header_field_splitter_unit mhfs_checker u_mhfs_checker (.*);
